/* hdl/block_interference_ratio_core_assert.svh */
// Assertion macros for the interference ratio core.
// The clock and reset names are those of the including scope.
`ifndef BLOCK_INTERFERENCE_RATIO_CORE_ASSERT_SVH
`define BLOCK_INTERFERENCE_RATIO_CORE_ASSERT_SVH

// Same-cycle implication.
`define BIR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BIR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/bir_pkg.sv */
`default_nettype none
package bir_pkg;

   localparam int COUNT_BITS = 21;
   localparam int FRAC_BITS  = 16;

   localparam int SAMPLE_BITS = 16;
   localparam int SQE_BITS    = 31;               // a*a <= 2^30
   localparam int SQD_BITS    = 32;               // (a-b)^2 < 2^32
   localparam int EO_BITS     = COUNT_BITS + 31;
   localparam int ED_BITS     = COUNT_BITS + 33;
   localparam int DEN_BITS    = EO_BITS + 1;
   localparam int REM_BITS    = ED_BITS + 1;
   localparam int RATIO_BITS  = FRAC_BITS + 2;
   localparam int CNT_BITS    = $clog2(FRAC_BITS + 1);

   localparam logic [RATIO_BITS-1:0] RATIO_MAX = {2'b10, {FRAC_BITS{1'b0}}};

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [RATIO_BITS-1:0]         ratio_type;

   typedef struct packed {
      logic load;    // latch numerator/denominator, clear sums
      logic check;   // zero and clamp decision, init quotient
      logic step;    // one restoring division step
   } bir_cmd_type;

   typedef struct packed {
      logic last_acc;   // last pair being accumulated this cycle
      logic den_zero;
      logic clamp;      // numerator >= 2 * denominator
      logic div_done;   // final quotient bit in this step
   } bir_status_type;

endpackage
`default_nettype wire

/* hdl/bir_req_if.sv */
`default_nettype none
interface bir_req_if;
   import bir_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_orig;
   sample_type sample_rev;
   logic       last;

   modport source (output valid, output sample_orig, output sample_rev, output last,
                   input ready);
   modport sink   (input valid, input sample_orig, input sample_rev, input last,
                   output ready);
endinterface
`default_nettype wire

/* hdl/bir_rsp_if.sv */
`default_nettype none
interface bir_rsp_if;
   import bir_pkg::*;

   logic      valid;
   logic      ready;
   ratio_type ratio;
   logic      zero_energy;

   modport source (output valid, output ratio, output zero_energy, input ready);
   modport sink   (input valid, input ratio, input zero_energy, output ready);
endinterface
`default_nettype wire

/* hdl/block_interference_ratio_core.sv */
// The result beat follows the last beat through the square stage, load, check
// and the serial division steps; zero energies or a clamp at two skip the division.
// Throughput: one sample pair per cycle while a block accumulates; from the
// last beat until the result beat is taken no pairs are accepted (serial divider).
// Reset (synchronous, active high) clears the sums and returns to accumulation.
`default_nettype none
module block_interference_ratio_core
   import bir_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   bir_req_if.sink   req_if,
   bir_rsp_if.source rsp_if
);

   `include "block_interference_ratio_core_assert.svh"

   bir_cmd_type    cmd;
   bir_status_type status;
   logic           req_ready;
   logic           req_fire;

   // Pair accepted into the square stage.
   assign req_fire     = req_if.valid && req_ready;
   assign req_if.ready = req_ready;

   // Controller: accumulate, load, check, divide, present result.
   bir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_if.valid)
   );

   // Datapath: squares, saturating sums, shared restoring divider.
   // Result fields sit in the quotient and zero registers and hold while the beat stalls.
   bir_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .sample_orig (req_if.sample_orig),
      .sample_rev  (req_if.sample_rev),
      .last        (req_if.last),
      .cmd         (cmd),
      .status      (status),
      .ratio       (rsp_if.ratio),
      .zero_energy (rsp_if.zero_energy)
   );

   // No pair is taken while a result is pending.
   `BIR_ASSERT_IMPL(a_no_req_during_rsp, rsp_if.valid, !req_if.ready,
                    "pair accepted while result pending")
   // The last pair always stalls the input on the following cycle.
   `BIR_ASSERT_NEXT(a_last_stalls, req_if.valid && req_if.ready && req_if.last,
                    !req_if.ready, "input not stalled after last pair")
   // Zero energy reports a zero ratio.
   `BIR_ASSERT_IMPL(a_zero_ratio, rsp_if.valid && rsp_if.zero_energy,
                    rsp_if.ratio == '0, "nonzero ratio with zero energy")
   // Ratio never exceeds two.
   `BIR_ASSERT_IMPL(a_ratio_range, rsp_if.valid, rsp_if.ratio <= RATIO_MAX,
                    "ratio above two")

endmodule
`default_nettype wire

/* hdl/bir_ctrl.sv */
`default_nettype none
module bir_ctrl
   import bir_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bir_status_type status,
   input  wire logic           rsp_ready,
   output bir_cmd_type         cmd,
   output logic                req_ready,
   output logic                rsp_valid
);

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (status.last_acc) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (status.den_zero || status.clamp) ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold off new pairs while the last pair is still in the square stage.
   assign req_ready = (state_ff == ST_RUN) && !status.last_acc;
   assign rsp_valid = (state_ff == ST_OUT);
   assign cmd.load  = (state_ff == ST_LOAD);
   assign cmd.check = (state_ff == ST_CHECK);
   assign cmd.step  = (state_ff == ST_DIV);

endmodule
`default_nettype wire

/* hdl/bir_datapath.sv */
`default_nettype none
module bir_datapath
   import bir_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_fire,
   input  wire sample_type  sample_orig,
   input  wire sample_type  sample_rev,
   input  wire logic        last,
   input  wire bir_cmd_type cmd,
   output bir_status_type   status,
   output ratio_type        ratio,
   output logic             zero_energy
);

   // square stage
   logic signed [2*SAMPLE_BITS-1:0] prod_orig;
   logic signed [2*SAMPLE_BITS-1:0] prod_rev;
   logic signed [SAMPLE_BITS:0]     diff;
   logic signed [2*SAMPLE_BITS+1:0] prod_diff;

   logic [SQE_BITS-1:0] sq_orig_ff;
   logic [SQE_BITS-1:0] sq_rev_ff;
   logic [SQD_BITS-1:0] sq_diff_ff;
   logic                s1_valid_ff;
   logic                s1_last_ff;

   assign prod_orig = sample_orig * sample_orig;
   assign prod_rev  = sample_rev * sample_rev;
   assign diff      = (SAMPLE_BITS+1)'(sample_orig) - (SAMPLE_BITS+1)'(sample_rev);
   assign prod_diff = (2*SAMPLE_BITS+2)'(diff) * (2*SAMPLE_BITS+2)'(diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
      sq_orig_ff <= prod_orig[SQE_BITS-1:0];
      sq_rev_ff  <= prod_rev[SQE_BITS-1:0];
      sq_diff_ff <= prod_diff[SQD_BITS-1:0];
      s1_last_ff <= last;
   end

   // saturating accumulators
   logic [EO_BITS:0] sum_orig;
   logic [EO_BITS:0] sum_rev;
   logic [ED_BITS:0] sum_diff;
   logic [EO_BITS-1:0] eo_ff, eo_in;
   logic [EO_BITS-1:0] er_ff, er_in;
   logic [ED_BITS-1:0] ed_ff, ed_in;

   assign sum_orig = {1'b0, eo_ff} + (EO_BITS+1)'(sq_orig_ff);
   assign sum_rev  = {1'b0, er_ff} + (EO_BITS+1)'(sq_rev_ff);
   assign sum_diff = {1'b0, ed_ff} + (ED_BITS+1)'(sq_diff_ff);

   always_comb begin
      eo_in = eo_ff;
      er_in = er_ff;
      ed_in = ed_ff;
      if (cmd.load) begin
         eo_in = '0;
         er_in = '0;
         ed_in = '0;
      end else if (s1_valid_ff) begin
         eo_in = sum_orig[EO_BITS] ? '1 : sum_orig[EO_BITS-1:0];
         er_in = sum_rev[EO_BITS]  ? '1 : sum_rev[EO_BITS-1:0];
         ed_in = sum_diff[ED_BITS] ? '1 : sum_diff[ED_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eo_ff <= '0;
         er_ff <= '0;
         ed_ff <= '0;
      end else begin
         eo_ff <= eo_in;
         er_ff <= er_in;
         ed_ff <= ed_in;
      end
   end

   // restoring divider, one quotient bit per step, integer bit first
   logic [DEN_BITS-1:0]   den_ff;
   logic [REM_BITS-1:0]   rem_ff;
   logic [RATIO_BITS-1:0] quot_ff;
   logic                  zero_ff;
   logic [CNT_BITS-1:0]   cnt_ff;

   logic [REM_BITS-1:0] den_ext;
   logic [REM_BITS-1:0] trial;
   logic                trial_ge;

   assign den_ext  = REM_BITS'(den_ff);
   assign trial    = (cnt_ff == '0) ? rem_ff : {rem_ff[REM_BITS-2:0], 1'b0};
   assign trial_ge = (trial >= den_ext);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         den_ff <= DEN_BITS'(eo_ff) + DEN_BITS'(er_ff);
         rem_ff <= REM_BITS'(ed_ff);
      end else if (cmd.step) begin
         rem_ff <= trial_ge ? (trial - den_ext) : trial;
      end

      if (cmd.check) begin
         cnt_ff  <= '0;
         zero_ff <= status.den_zero;
         if (status.den_zero) begin
            quot_ff <= '0;
         end else if (status.clamp) begin
            quot_ff <= RATIO_MAX;
         end else begin
            quot_ff <= '0;
         end
      end else if (cmd.step) begin
         cnt_ff  <= cnt_ff + 1'b1;
         quot_ff <= {quot_ff[RATIO_BITS-2:0], trial_ge};
      end
   end

   assign status.last_acc = s1_valid_ff & s1_last_ff;
   assign status.den_zero = (den_ff == '0);
   assign status.clamp    = (rem_ff >= REM_BITS'({den_ff, 1'b0}));
   assign status.div_done = (cnt_ff == CNT_BITS'(FRAC_BITS));

   assign ratio       = quot_ff;
   assign zero_energy = zero_ff;

endmodule
`default_nettype wire

/* tb/bir_ratio_checker.sv */
`timescale 1ns / 100ps
// Watches both channels, tracks the three energy sums and checks each
// result beat against the ratio owed for the oldest finished block.
module bir_ratio_checker
   import bir_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   bir_req_if        req_mon,
   bir_rsp_if        rsp_mon,
   output int        fail_count,
   output int        ratios_pending
);

   typedef struct packed {
      ratio_type ratio;
      logic      zero_energy;
   } ratio_beat_type;

   logic [EO_BITS-1:0] sum_orig;
   logic [EO_BITS-1:0] sum_rev;
   logic [ED_BITS-1:0] sum_diff;
   ratio_beat_type     block_ratios [$];
   int                 mismatches;

   assign fail_count = mismatches;

   // floor(diff * 2^FRAC_BITS / (orig + rev)), clamped at two
   function automatic ratio_beat_type block_ratio(input logic [EO_BITS-1:0] eo,
                                                  input logic [EO_BITS-1:0] er,
                                                  input logic [ED_BITS-1:0] ed);
      logic [127:0]   den;
      logic [127:0]   num;
      ratio_beat_type res;
      den = eo;
      den = den + er;
      num = ed;
      res.zero_energy = (den == 0);
      if (den == 0) begin
         res.ratio = '0;
      end else if (num >= (den << 1)) begin
         res.ratio = RATIO_MAX;
      end else begin
         num = (num << FRAC_BITS) / den;
         res.ratio = num[RATIO_BITS-1:0];
      end
      return res;
   endfunction

   task automatic accumulate_pair(input sample_type a, input sample_type b);
      logic signed [31:0] a_sq;
      logic signed [31:0] b_sq;
      logic signed [16:0] dif;
      logic signed [33:0] d_sq;
      logic [EO_BITS:0]   sum_o;
      logic [EO_BITS:0]   sum_r;
      logic [ED_BITS:0]   sum_d;
      a_sq = a * a;
      b_sq = b * b;
      dif = a - b;
      d_sq = dif * dif;
      sum_o = sum_orig + a_sq[30:0];
      sum_r = sum_rev + b_sq[30:0];
      sum_d = sum_diff + d_sq[31:0];
      // saturate at all ones on carry out
      sum_orig = sum_o[EO_BITS] ? '1 : sum_o[EO_BITS-1:0];
      sum_rev  = sum_r[EO_BITS] ? '1 : sum_r[EO_BITS-1:0];
      sum_diff = sum_d[ED_BITS] ? '1 : sum_d[ED_BITS-1:0];
   endtask

   always @(posedge clock) begin : monitor
      ratio_beat_type want;
      if (reset) begin
         sum_orig = '0;
         sum_rev  = '0;
         sum_diff = '0;
         block_ratios.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (block_ratios.size() == 0) begin
               $error("unexpected result beat: ratio %0d zero_energy %0b",
                      rsp_mon.ratio, rsp_mon.zero_energy);
               mismatches++;
            end else begin
               want = block_ratios.pop_front();
               if (rsp_mon.ratio !== want.ratio) begin
                  $error("ratio: expected %0d, actual %0d", want.ratio, rsp_mon.ratio);
                  mismatches++;
               end
               if (rsp_mon.zero_energy !== want.zero_energy) begin
                  $error("zero_energy: expected %0b, actual %0b",
                         want.zero_energy, rsp_mon.zero_energy);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            accumulate_pair(req_mon.sample_orig, req_mon.sample_rev);
            if (req_mon.last) begin
               block_ratios.push_back(block_ratio(sum_orig, sum_rev, sum_diff));
               sum_orig = '0;
               sum_rev  = '0;
               sum_diff = '0;
            end
         end
      end
      ratios_pending <= block_ratios.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for the interference ratio core. Prediction and
// comparison live in the checker beside the core.
module tb_top;
   import bir_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   ratios_pending;

   bir_req_if req_ch ();
   bir_rsp_if rsp_ch ();

   // full-scale and near-zero sample values
   int corner_vals [5] = '{-32768, -1, 0, 1, 32767};

   localparam int RANDOM_ITEMS = 1600;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   block_interference_ratio_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   bir_ratio_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .fail_count     (fail_count),
      .ratios_pending (ratios_pending)
   );

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic int rand_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return int'($urandom_range(0, 65535)) - 32768;
      if (pick < 75) return corner_vals[$urandom_range(0, 4)];
      if (pick < 90) return int'($urandom_range(0, 16)) - 8;
      return 0;
   endfunction

   // Offer one pair and hold it until the core takes the beat.
   task automatic send_pair(input int orig, input int rev, input logic last_pair);
      req_ch.valid       <= 1'b1;
      req_ch.sample_orig <= orig[15:0];
      req_ch.sample_rev  <= rev[15:0];
      req_ch.last        <= last_pair;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // One block of random pairs. A silent block is all zeros, so its ratio
   // falls on the zero-energy case. A burst block goes without gaps.
   task automatic send_block(input int len, input logic silent, input logic burst);
      int orig;
      int rev;
      int pick;
      for (int i = 0; i < len; i++) begin
         if (silent) begin
            orig = 0;
            rev  = 0;
         end else begin
            orig = rand_sample();
            pick = $urandom_range(0, 99);
            if (pick < 8) rev = orig;            // no difference
            else if (pick < 15) rev = -orig;     // difference doubles
            else rev = rand_sample();
         end
         send_pair(orig, rev, i == len - 1);
         if (!burst) pause_sender(idle_len());
      end
   endtask

   // Result side: random holds with quiet stretches, plus two long
   // hold-offs while the sender keeps pushing, so the core backs up.
   initial begin : result_sink
      int taken;
      int quiet_left;
      int hold;
      taken = 0;
      quiet_left = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == 30 || taken == 80) begin
            hold = 400;
         end else if (quiet_left > 0) begin
            hold = 0;
            quiet_left--;
         end else begin
            hold = idle_len();
            if ($urandom_range(0, 9) == 0) quiet_left = $urandom_range(5, 20);
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         taken++;
      end
   end

   initial begin : stimulus
      int sent;
      int len;
      int pick;
      logic silent;
      logic burst;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.sample_orig <= '0;
      req_ch.sample_rev  <= '0;
      req_ch.last        <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: zero energy, single and multi-pair
      send_pair(0, 0, 1'b1);
      send_pair(0, 0, 1'b0);
      send_pair(0, 0, 1'b0);
      send_pair(0, 0, 1'b1);
      // full-scale opposite signs: ratio just under two
      send_pair(32767, -32768, 1'b1);
      send_pair(-32768, 32767, 1'b1);
      // equal samples: ratio zero
      send_pair(-32768, -32768, 1'b1);
      send_pair(32767, 32767, 1'b1);
      // one stream silent: ratio exactly one
      send_pair(12345, 0, 1'b1);
      send_pair(0, -1, 1'b1);
      // ratio exactly two: clamp path without saturation
      send_pair(0, 0, 1'b0);
      send_pair(1, -1, 1'b1);
      // mixed short block with gaps
      send_pair(100, 99, 1'b0);
      pause_sender(3);
      send_pair(-5, 7, 1'b0);
      send_pair(-1, 32767, 1'b1);
      pause_sender(5);

      // random blocks, mostly short
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) len = $urandom_range(1, 8);
         else if (pick < 95) len = $urandom_range(9, 40);
         else len = $urandom_range(41, 120);
         silent = ($urandom_range(0, 9) == 0);
         burst  = ($urandom_range(0, 3) == 0);
         send_block(len, silent, burst);
         sent += len;
      end
      req_ch.valid <= 1'b0;

      // drain: wait for every owed ratio, then idle before the verdict
      @(posedge clock);
      while (ratios_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("block_interference_ratio_core: match");
      end else begin
         $display("block_interference_ratio_core: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("block_interference_ratio_core: mismatch");
      $finish;
   end

endmodule
